[hdl/bblur_pkg.sv]
package bblur_pkg;

   // default sizes of the top level
   localparam int MAX_WIDTH_DEF    = 1024;
   localparam int CHANNEL_BITS_DEF = 8;

   // result queue between the filter pipeline and the output channel
   localparam int FIFO_DEPTH = 8;

   // configuration registers
   localparam int WIDTH_BITS  = 11;
   localparam int HEIGHT_BITS = 16;
   localparam int ROW_BITS    = 16;
   localparam logic [WIDTH_BITS-1:0]  WIDTH_RESET  = 11'd640;
   localparam logic [HEIGHT_BITS-1:0] HEIGHT_RESET = 16'd480;
   localparam int MIN_DIM = 3;

   // CSR port: one register every 4 bytes, selected by address bit 2
   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = 32;
   localparam int REG_SEL_BIT   = 2;
   localparam logic REG_WIDTH  = 1'b0;
   localparam logic REG_HEIGHT = 1'b1;

   // item operations
   localparam logic OP_PIXEL = 1'b0;
   localparam logic OP_DRAIN = 1'b1;

   // 3x3 window geometry and mean arithmetic
   localparam int NUM_CH     = 3;
   localparam int WIN_COLS   = 3;
   localparam int WIN_TAPS   = 9;
   localparam int WIN_CENTER = 4;
   localparam int DIVISOR    = 9;
   localparam int ROUND_BIAS = 4;

   // result queue control
   typedef struct packed {
      logic reserve;   // an accepted item will produce a result
      logic push;      // a result leaves the pipeline
      logic pop;       // a result transfer on the output channel
   } fifo_ctl_type;

endpackage

[hdl/bblur_ram.sv]
module bblur_ram #(
   parameter int WIDTH = 3 * bblur_pkg::CHANNEL_BITS_DEF,
   parameter int DEPTH = bblur_pkg::MAX_WIDTH_DEF,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // one write port, one registered read port; read returns old data on collision
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[hdl/bblur_mean.sv]
module bblur_mean #(
   parameter int CHANNEL_BITS = bblur_pkg::CHANNEL_BITS_DEF,
   localparam int PIX_W = bblur_pkg::NUM_CH * CHANNEL_BITS
) (
   input  logic             clock,
   input  logic [PIX_W-1:0] window [bblur_pkg::WIN_TAPS],
   output logic [PIX_W-1:0] mean
);

   // sum of nine samples plus rounding bias fits in four extra bits
   localparam int SUM_W   = CHANNEL_BITS + 4;
   // reciprocal of 9 exact for every sum below 2**SUM_W
   localparam int SHIFT   = SUM_W + 4;
   localparam int RECIP_W = SHIFT - 2;
   localparam logic [RECIP_W-1:0] RECIP =
      RECIP_W'((2 ** SHIFT + bblur_pkg::DIVISOR - 1) / bblur_pkg::DIVISOR);
   localparam int PROD_W  = SUM_W + RECIP_W;

   logic [SUM_W-1:0]  row_sum [bblur_pkg::NUM_CH][bblur_pkg::WIN_COLS];
   logic [SUM_W-1:0]  sum_in  [bblur_pkg::NUM_CH];
   logic [SUM_W-1:0]  sum_ff  [bblur_pkg::NUM_CH];
   logic [PROD_W-1:0] prod    [bblur_pkg::NUM_CH];

   // stage 1: per channel, three row sums and their total with bias
   always_comb begin
      for (int k = 0; k < bblur_pkg::NUM_CH; k++) begin
         for (int r = 0; r < bblur_pkg::WIN_COLS; r++) begin
            row_sum[k][r] =
               SUM_W'(window[r*3][k*CHANNEL_BITS +: CHANNEL_BITS]) +
               SUM_W'(window[r*3+1][k*CHANNEL_BITS +: CHANNEL_BITS]) +
               SUM_W'(window[r*3+2][k*CHANNEL_BITS +: CHANNEL_BITS]);
         end
         sum_in[k] = SUM_W'(bblur_pkg::ROUND_BIAS) + row_sum[k][0] + row_sum[k][1] +
                     row_sum[k][2];
      end
   end

   always_ff @(posedge clock) begin
      sum_ff <= sum_in;
   end

   // stage 2: divide by nine through the reciprocal
   always_comb begin
      for (int k = 0; k < bblur_pkg::NUM_CH; k++) begin
         prod[k] = PROD_W'(sum_ff[k]) * PROD_W'(RECIP);
         mean[k*CHANNEL_BITS +: CHANNEL_BITS] = prod[k][SHIFT +: CHANNEL_BITS];
      end
   end

endmodule

[hdl/bblur_fifo.sv]
module bblur_fifo #(
   parameter int WIDTH = 3 * bblur_pkg::CHANNEL_BITS_DEF + 1,
   parameter int DEPTH = bblur_pkg::FIFO_DEPTH,
   localparam int PTR_W = $clog2(DEPTH),
   localparam int CNT_W = $clog2(DEPTH + 1)
) (
   input  logic                     clock,
   input  logic                     reset,
   input  bblur_pkg::fifo_ctl_type  ctl,
   input  logic [WIDTH-1:0]         push_data,
   output logic                     space,
   output logic                     out_valid,
   output logic [WIDTH-1:0]         out_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] resv_ff, resv_in;

   // slots held by results queued or still in flight
   always_comb begin
      resv_in  = resv_ff + CNT_W'(ctl.reserve) - CNT_W'(ctl.pop);
      count_in = count_ff + CNT_W'(ctl.push) - CNT_W'(ctl.pop);
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (ctl.push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (ctl.pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
         resv_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
         resv_ff   <= resv_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (ctl.push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign space     = (resv_ff != CNT_W'(DEPTH));
   assign out_valid = (count_ff != '0);
   assign out_data  = mem_ff[rd_ptr_ff];

endmodule

[hdl/box_blur_3x3_rgb.sv]
// 3x3 box blur on a raster RGB stream. Each pixel leaves as the rounded mean of its original
// 3x3 neighborhood per channel; the outermost rows and columns pass unchanged. The result for
// a pixel is released by the input pixel one row plus one pixel later, and after the frame's
// last pixel the user sends image_width + 1 drain items (operation = 1) to push out the rest;
// the final one carries frame_end. One item is taken every clock while req_ready is high: each
// pixel item makes one read and one write to each of two line memories (MAX_WIDTH x
// 3*CHANNEL_BITS, one write and one read port each), a drain only reads, and a result runs
// through stages B, C, D and the result queue to rsp. req_ready drops only while eight results
// are queued or in flight and not yet transferred. The line memories need no clearing after
// reset. Writing either CSR restarts the frame, and must be done only while the block is idle.
module box_blur_3x3_rgb #(
   parameter int MAX_WIDTH    = bblur_pkg::MAX_WIDTH_DEF,
   parameter int CHANNEL_BITS = bblur_pkg::CHANNEL_BITS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic                                  req_operation,
   input  logic [CHANNEL_BITS-1:0]               req_red_in,
   input  logic [CHANNEL_BITS-1:0]               req_green_in,
   input  logic [CHANNEL_BITS-1:0]               req_blue_in,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [CHANNEL_BITS-1:0]               rsp_red_out,
   output logic [CHANNEL_BITS-1:0]               rsp_green_out,
   output logic [CHANNEL_BITS-1:0]               rsp_blue_out,
   output logic                                  rsp_frame_end,
   input  logic                                  csr_psel,
   input  logic                                  csr_penable,
   input  logic                                  csr_pwrite,
   input  logic [bblur_pkg::CSR_ADDR_BITS-1:0]   csr_paddr,
   input  logic [bblur_pkg::CSR_DATA_BITS-1:0]   csr_pwdata,
   output logic [bblur_pkg::CSR_DATA_BITS-1:0]   csr_prdata,
   output logic                                  csr_pready
);

   localparam int PIX_W  = bblur_pkg::NUM_CH * CHANNEL_BITS;
   localparam int RSP_W  = PIX_W + 1;
   localparam int COL_W  = $clog2(MAX_WIDTH);
   localparam int W_W    = $clog2(MAX_WIDTH + 1);
   localparam int CMP_W  = W_W + 1;
   localparam int ROW_W  = bblur_pkg::ROW_BITS;
   localparam int RCMP_W = ROW_W + 1;
   localparam int WB     = bblur_pkg::WIDTH_BITS;
   localparam int HB     = bblur_pkg::HEIGHT_BITS;
   localparam int DB     = bblur_pkg::CSR_DATA_BITS;

   // ---------------------------------------------------------------- CSRs
   logic          csr_write;
   logic          csr_sel;
   logic [WB-1:0] width_ff, width_in;
   logic [HB-1:0] height_ff, height_in;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign csr_sel    = csr_paddr[bblur_pkg::REG_SEL_BIT];

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_write) begin
         unique case (csr_sel)
            bblur_pkg::REG_WIDTH:  width_in  = csr_pwdata[WB-1:0];
            bblur_pkg::REG_HEIGHT: height_in = csr_pwdata[HB-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_sel)
         bblur_pkg::REG_WIDTH:  csr_prdata = DB'(width_ff);
         bblur_pkg::REG_HEIGHT: csr_prdata = DB'(height_ff);
         default:               csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= bblur_pkg::WIDTH_RESET;
         height_ff <= bblur_pkg::HEIGHT_RESET;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
      end
   end

   // effective frame size, clamped to the supported range
   logic [W_W-1:0]   w_eff;
   logic [ROW_W-1:0] h_eff;

   always_comb begin
      priority if (width_ff < WB'(bblur_pkg::MIN_DIM)) begin
         w_eff = W_W'(bblur_pkg::MIN_DIM);
      end else if (32'(width_ff) > MAX_WIDTH) begin
         w_eff = W_W'(MAX_WIDTH);
      end else begin
         w_eff = W_W'(width_ff);
      end
      h_eff = (height_ff < HB'(bblur_pkg::MIN_DIM)) ? ROW_W'(bblur_pkg::MIN_DIM)
                                                   : ROW_W'(height_ff);
   end

   // ---------------------------------------------------------------- stage A: accept
   logic [COL_W-1:0] in_col_ff, in_col_in;
   logic [ROW_W-1:0] in_row_ff, in_row_in;
   logic [COL_W-1:0] out_col_ff, out_col_in;
   logic [ROW_W-1:0] out_row_ff, out_row_in;

   logic             req_fire;
   logic             is_pixel;
   logic             pix_act;
   logic             pix_emit;
   logic             drain_emit;
   logic             emit_a;
   logic             in_col_last;
   logic             out_col_last;
   logic             out_row_last;
   logic             last_a;
   logic             interior_a;
   logic [COL_W-1:0] rd_addr;
   logic             fifo_space;

   assign req_ready = fifo_space;
   assign req_fire  = req_valid & req_ready;

   always_comb begin
      is_pixel   = (req_operation == bblur_pkg::OP_PIXEL);
      pix_act    = is_pixel && (in_row_ff < h_eff);
      pix_emit   = pix_act && ((in_row_ff > ROW_W'(1)) ||
                               ((in_row_ff == ROW_W'(1)) && (in_col_ff != '0)));
      drain_emit = (req_operation == bblur_pkg::OP_DRAIN) && (in_row_ff >= h_eff);
      emit_a     = pix_emit || drain_emit;

      in_col_last  = (CMP_W'(in_col_ff) + CMP_W'(1) == CMP_W'(w_eff));
      out_col_last = (CMP_W'(out_col_ff) + CMP_W'(1) == CMP_W'(w_eff));
      out_row_last = (RCMP_W'(out_row_ff) + RCMP_W'(1) == RCMP_W'(h_eff));
      last_a       = out_row_last && out_col_last;
      interior_a   = (out_row_ff != '0) &&
                     (RCMP_W'(out_row_ff) + RCMP_W'(2) <= RCMP_W'(h_eff)) &&
                     (out_col_ff != '0) &&
                     (CMP_W'(out_col_ff) + CMP_W'(2) <= CMP_W'(w_eff));

      // a pixel reads its own column, a drain the column of the pending output
      rd_addr = is_pixel ? in_col_ff : out_col_ff;
   end

   // position counters
   always_comb begin
      in_col_in  = in_col_ff;
      in_row_in  = in_row_ff;
      out_col_in = out_col_ff;
      out_row_in = out_row_ff;
      if (csr_write) begin
         in_col_in  = '0;
         in_row_in  = '0;
         out_col_in = '0;
         out_row_in = '0;
      end else if (req_fire) begin
         if (pix_act) begin
            if (in_col_last) begin
               in_col_in = '0;
               in_row_in = in_row_ff + ROW_W'(1);
            end else begin
               in_col_in = in_col_ff + COL_W'(1);
            end
         end
         if (emit_a) begin
            if (last_a) begin
               in_col_in  = '0;
               in_row_in  = '0;
               out_col_in = '0;
               out_row_in = '0;
            end else if (out_col_last) begin
               out_col_in = '0;
               out_row_in = out_row_ff + ROW_W'(1);
            end else begin
               out_col_in = out_col_ff + COL_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_col_ff  <= '0;
         in_row_ff  <= '0;
         out_col_ff <= '0;
         out_row_ff <= '0;
      end else begin
         in_col_ff  <= in_col_in;
         in_row_ff  <= in_row_in;
         out_col_ff <= out_col_in;
         out_row_ff <= out_row_in;
      end
   end

   // ---------------------------------------------------------------- stage B: line memories
   logic             b_wr_ff, b_wr_in;
   logic             b_drain_ff, b_drain_in;
   logic             b_emit_ff, b_emit_in;
   logic             b_fwd_ff, b_fwd_in;
   logic [COL_W-1:0] b_col_ff;
   logic [PIX_W-1:0] b_px_ff;
   logic             b_interior_ff;
   logic             b_last_ff;
   logic             b_sel_mid_ff;
   logic [PIX_W-1:0] b_fwd_up_ff;
   logic [PIX_W-1:0] b_fwd_mid_ff;

   logic [PIX_W-1:0] up_rd, mid_rd;
   logic [PIX_W-1:0] up_eff, mid_eff;
   logic [PIX_W-1:0] drain_val;

   // a read that hits the column being written this cycle takes the write data
   always_comb begin
      b_wr_in    = req_fire && pix_act;
      b_drain_in = req_fire && drain_emit;
      b_emit_in  = req_fire && emit_a;
      b_fwd_in   = req_fire && b_wr_ff && (b_col_ff == rd_addr);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_wr_ff    <= 1'b0;
         b_drain_ff <= 1'b0;
         b_emit_ff  <= 1'b0;
         b_fwd_ff   <= 1'b0;
      end else begin
         b_wr_ff    <= b_wr_in;
         b_drain_ff <= b_drain_in;
         b_emit_ff  <= b_emit_in;
         b_fwd_ff   <= b_fwd_in;
      end
   end

   always_ff @(posedge clock) begin
      b_col_ff      <= rd_addr;
      b_px_ff       <= {req_blue_in, req_green_in, req_red_in};
      b_interior_ff <= interior_a;
      b_last_ff     <= last_a;
      b_sel_mid_ff  <= out_row_last;
      b_fwd_up_ff   <= mid_eff;
      b_fwd_mid_ff  <= b_px_ff;
   end

   bblur_ram #(
      .WIDTH (PIX_W),
      .DEPTH (MAX_WIDTH)
   ) u_upper_ram (
      .clock   (clock),
      .wr_en   (b_wr_ff),
      .wr_addr (b_col_ff),
      .wr_data (mid_eff),
      .rd_addr (rd_addr),
      .rd_data (up_rd)
   );

   bblur_ram #(
      .WIDTH (PIX_W),
      .DEPTH (MAX_WIDTH)
   ) u_middle_ram (
      .clock   (clock),
      .wr_en   (b_wr_ff),
      .wr_addr (b_col_ff),
      .wr_data (b_px_ff),
      .rd_addr (rd_addr),
      .rd_data (mid_rd)
   );

   assign up_eff    = b_fwd_ff ? b_fwd_up_ff : up_rd;
   assign mid_eff   = b_fwd_ff ? b_fwd_mid_ff : mid_rd;
   assign drain_val = b_sel_mid_ff ? mid_eff : up_eff;

   // 3x3 window: shift left, newest column from the memories and the input
   logic [PIX_W-1:0] win_ff [bblur_pkg::WIN_TAPS];
   logic [PIX_W-1:0] win_in [bblur_pkg::WIN_TAPS];

   always_comb begin
      win_in = win_ff;
      if (b_wr_ff) begin
         for (int r = 0; r < bblur_pkg::WIN_COLS; r++) begin
            win_in[r*3]   = win_ff[r*3+1];
            win_in[r*3+1] = win_ff[r*3+2];
         end
         win_in[2] = up_eff;
         win_in[5] = mid_eff;
         win_in[8] = b_px_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < bblur_pkg::WIN_TAPS; i++) begin
            win_ff[i] <= '0;
         end
      end else begin
         win_ff <= win_in;
      end
   end

   // ---------------------------------------------------------------- stage C: window sums
   logic             c_emit_ff;
   logic             c_drain_ff;
   logic             c_use_mean_ff;
   logic             c_last_ff;
   logic [PIX_W-1:0] c_val_ff;
   logic [PIX_W-1:0] mean;

   always_ff @(posedge clock) begin
      if (reset) begin
         c_emit_ff <= 1'b0;
      end else begin
         c_emit_ff <= b_emit_ff;
      end
   end

   always_ff @(posedge clock) begin
      c_drain_ff    <= b_drain_ff;
      c_use_mean_ff <= b_wr_ff && b_interior_ff;
      c_last_ff     <= b_last_ff;
      c_val_ff      <= drain_val;
   end

   bblur_mean #(
      .CHANNEL_BITS (CHANNEL_BITS)
   ) u_mean (
      .clock  (clock),
      .window (win_ff),
      .mean   (mean)
   );

   // ---------------------------------------------------------------- stage D: divide, queue
   logic             d_emit_ff;
   logic             d_use_mean_ff;
   logic             d_last_ff;
   logic [PIX_W-1:0] d_val_ff;
   logic [PIX_W-1:0] d_pix;
   logic [RSP_W-1:0] rsp_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         d_emit_ff <= 1'b0;
      end else begin
         d_emit_ff <= c_emit_ff;
      end
   end

   // border pixels and drained pixels bypass the mean
   always_ff @(posedge clock) begin
      d_use_mean_ff <= c_use_mean_ff;
      d_last_ff     <= c_last_ff;
      d_val_ff      <= c_drain_ff ? c_val_ff : win_ff[bblur_pkg::WIN_CENTER];
   end

   assign d_pix = d_use_mean_ff ? mean : d_val_ff;

   bblur_pkg::fifo_ctl_type fifo_ctl;

   always_comb begin
      fifo_ctl.reserve = req_fire && emit_a;
      fifo_ctl.push    = d_emit_ff;
      fifo_ctl.pop     = rsp_valid && rsp_ready;
   end

   bblur_fifo #(
      .WIDTH (RSP_W),
      .DEPTH (bblur_pkg::FIFO_DEPTH)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .ctl       (fifo_ctl),
      .push_data ({d_last_ff, d_pix}),
      .space     (fifo_space),
      .out_valid (rsp_valid),
      .out_data  (rsp_data)
   );

   assign rsp_red_out   = rsp_data[0 +: CHANNEL_BITS];
   assign rsp_green_out = rsp_data[CHANNEL_BITS +: CHANNEL_BITS];
   assign rsp_blue_out  = rsp_data[2*CHANNEL_BITS +: CHANNEL_BITS];
   assign rsp_frame_end = rsp_data[PIX_W];

   // ---------------------------------------------------------------- assertions
   // the frame's last result returns all positions to the frame start
   a_frame_restart: assert property (@(posedge clock) disable iff (reset)
      (req_fire && emit_a && last_a) |=>
      (in_col_ff == '0 && in_row_ff == '0 && out_col_ff == '0 && out_row_ff == '0))
      else $error("positions not cleared after frame end");

   // the input row never runs past the frame
   a_row_bound: assert property (@(posedge clock) disable iff (reset)
      in_row_ff <= h_eff)
      else $error("input row beyond frame height");

   // forwarded read data only ever comes from a write in the previous cycle
   a_fwd_source: assert property (@(posedge clock) disable iff (reset)
      b_fwd_ff |-> $past(b_wr_ff))
      else $error("line memory forward without a write");

   // back-to-back pixel writes go to different columns
   a_col_advance: assert property (@(posedge clock) disable iff (reset)
      (b_wr_ff && $past(b_wr_ff)) |-> (b_col_ff != $past(b_col_ff)))
      else $error("consecutive pixel writes to the same column");

endmodule
